### sv/quaternion_to_euler_angles_assert.svh
// Assertion macros for the quaternion to Euler angle block.
// Used by the port checker; depends on nothing.
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// implication checked on every clock edge outside reset
`define QTE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("qte assertion failed");

// condition that must never hold outside reset
`define QTE_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("qte assertion failed");

`endif

### sv/qte_pkg.sv
// Shared types and constants for the quaternion to Euler angle pipeline.
// No dependencies.
package qte_pkg;
    localparam int XW = 38;   // CORDIC x/y datapath
    localparam int ZW = 35;   // CORDIC angle, 30 fraction bits
    localparam int SW = 34;   // sine-type terms, 28 fraction bits
    localparam int CW = 36;   // cosine-type terms, 28 fraction bits
    localparam int RTW = 29;  // square root width
    localparam int RDW = 57;  // radicand width

    localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [SW-1:0] ONE_Q28_S   = 34'sd268435456;
    localparam logic signed [CW-1:0] ONE_Q28_C   = 36'sd268435456;
    localparam int                   PI_Q13      = 25736;
    localparam int                   HALF_PI_Q13 = 12868;

    typedef struct packed {
        logic signed [SW-1:0] sr;
        logic signed [CW-1:0] cr;
        logic signed [SW-1:0] sy;
        logic signed [CW-1:0] cy;
        logic signed [SW-1:0] sp;
        logic                 clamp;
    } t_side;

    function automatic logic [29:0] atan_q30(input int idx);
        logic [29:0] v;
        case (idx)
            0:  v = 30'd843314856;
            1:  v = 30'd497837829;
            2:  v = 30'd263043836;
            3:  v = 30'd133525158;
            4:  v = 30'd67021686;
            5:  v = 30'd33543515;
            6:  v = 30'd16775850;
            7:  v = 30'd8388437;
            8:  v = 30'd4194282;
            9:  v = 30'd2097149;
            10: v = 30'd1048575;
            11: v = 30'd524287;
            12: v = 30'd262143;
            13: v = 30'd131071;
            14: v = 30'd65535;
            15: v = 30'd32767;
            16: v = 30'd16383;
            17: v = 30'd8191;
            18: v = 30'd4095;
            19: v = 30'd2047;
            20: v = 30'd1023;
            21: v = 30'd511;
            22: v = 30'd255;
            23: v = 30'd127;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

### sv/quaternion_to_euler_angles.sv
// Quaternion to roll/pitch/yaw, fully pipelined.
// Depends on qte_pkg, qte_sqrt and qte_cordic.
//
// Takes one Q2.14 quaternion per clock whenever start is high; busy stays low.
// Each transaction comes out as a one-cycle o_valid strobe with roll and yaw
// (Q3.13 rad), pitch (Q2.13 rad) and the pitch clamp flag.
// The pipeline is made of 3 product/sum stages, a 30-stage square root for the
// pitch cosine, ANGLE_ITERATIONS + 2 CORDIC stages and an output register.
// The receiver cannot hold off results; they must be captured on the strobe.
module quaternion_to_euler_angles import qte_pkg::*; #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  i_quat_w,
    input  logic signed [15:0]  i_quat_x,
    input  logic signed [15:0]  i_quat_y,
    input  logic signed [15:0]  i_quat_z,
    output logic                o_valid,
    output logic signed [15:0]  o_roll_angle,
    output logic signed [14:0]  o_pitch_angle,
    output logic signed [15:0]  o_yaw_angle,
    output logic                o_pitch_clamped
);
    localparam int LATC = ANGLE_ITERATIONS + 2;
    localparam int PAYW = $bits(t_side);
    localparam logic [RDW-1:0] ONE_Q56 = RDW'(1) << 56;
    localparam logic signed [14:0] P_HALF = 15'(HALF_PI_Q13);

    assign busy = 1'b0;

    // products
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    logic               r_v1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
        r_wx <= i_quat_w * i_quat_x;
        r_yz <= i_quat_y * i_quat_z;
        r_xx <= i_quat_x * i_quat_x;
        r_yy <= i_quat_y * i_quat_y;
        r_wz <= i_quat_w * i_quat_z;
        r_xy <= i_quat_x * i_quat_y;
        r_zz <= i_quat_z * i_quat_z;
        r_wy <= i_quat_w * i_quat_y;
        r_zx <= i_quat_z * i_quat_x;
    end

    // sums
    t_side r_s2;
    logic  r_v2;
    logic signed [SW-1:0] n_sp;
    assign n_sp = (SW'(r_wy) - SW'(r_zx)) <<< 1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_s2.sr    <= (SW'(r_wx) + SW'(r_yz)) <<< 1;
        r_s2.cr    <= ONE_Q28_C - ((CW'(r_xx) + CW'(r_yy)) <<< 1);
        r_s2.sy    <= (SW'(r_wz) + SW'(r_xy)) <<< 1;
        r_s2.cy    <= ONE_Q28_C - ((CW'(r_yy) + CW'(r_zz)) <<< 1);
        r_s2.sp    <= n_sp;
        r_s2.clamp <= (n_sp >= ONE_Q28_S) || (n_sp <= -ONE_Q28_S);
    end

    // pitch sine squared
    t_side              r_s3;
    logic               r_v3;
    logic signed [57:0] r_sq;
    logic signed [28:0] n_spt;
    assign n_spt = r_s2.clamp ? '0 : r_s2.sp[28:0];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_s3 <= r_s2;
        r_sq <= n_spt * n_spt;
    end

    logic [RDW-1:0] n_rad;
    assign n_rad = ONE_Q56 - r_sq[RDW-1:0];

    logic           sq_valid;
    logic [RTW-1:0] sq_root;
    logic [PAYW-1:0] sq_pay;
    t_side          sq_side;

    qte_sqrt #(.PW(PAYW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_rad   (n_rad),
        .i_pay   (r_s3),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_pay   (sq_pay)
    );
    assign sq_side = t_side'(sq_pay);

    logic signed [15:0] roll_ang, yaw_ang;
    logic signed [14:0] pitch_ang;
    logic               pitch_valid;

    qte_cordic #(.ITER(ANGLE_ITERATIONS), .OW(16), .LIMIT(PI_Q13)) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_y     (XW'(sq_side.sr)),
        .i_x     (XW'(sq_side.cr)),
        .o_valid (),
        .o_angle (roll_ang)
    );

    qte_cordic #(.ITER(ANGLE_ITERATIONS), .OW(15), .LIMIT(HALF_PI_Q13)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_y     (XW'(sq_side.sp)),
        .i_x     (XW'(sq_root)),
        .o_valid (pitch_valid),
        .o_angle (pitch_ang)
    );

    qte_cordic #(.ITER(ANGLE_ITERATIONS), .OW(16), .LIMIT(PI_Q13)) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_y     (XW'(sq_side.sy)),
        .i_x     (XW'(sq_side.cy)),
        .o_valid (),
        .o_angle (yaw_ang)
    );

    // clamp flag and sign ride alongside the CORDIC
    logic [1:0] r_cl_d [0:LATC-1];
    always_ff @(posedge i_clk) begin
        r_cl_d[0] <= {sq_side.clamp, sq_side.sp[SW-1]};
        for (int i = 1; i < LATC; i++) begin
            r_cl_d[i] <= r_cl_d[i-1];
        end
    end

    logic               r_ov;
    logic signed [15:0] r_roll, r_yaw;
    logic signed [14:0] r_pitch;
    logic               r_clamp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= pitch_valid;
        end
        r_roll  <= roll_ang;
        r_yaw   <= yaw_ang;
        r_clamp <= r_cl_d[LATC-1][1];
        if (r_cl_d[LATC-1][1]) begin
            r_pitch <= r_cl_d[LATC-1][0] ? -P_HALF : P_HALF;
        end else begin
            r_pitch <= pitch_ang;
        end
    end

    assign o_valid         = r_ov;
    assign o_roll_angle    = r_roll;
    assign o_pitch_angle   = r_pitch;
    assign o_yaw_angle     = r_yaw;
    assign o_pitch_clamped = r_clamp;
endmodule

### sv/qte_sqrt.sv
// Pipelined integer square root, one result bit per stage, with side payload.
// Depends on qte_pkg.
module qte_sqrt import qte_pkg::*; #(
    parameter int PW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [RDW-1:0] i_rad,
    input  logic [PW-1:0]  i_pay,
    output logic           o_valid,
    output logic [RTW-1:0] o_root,
    output logic [PW-1:0]  o_pay
);
    localparam int RW = RDW + 2;

    logic [RW-1:0]  r_rem  [0:RTW];
    logic [RTW-1:0] r_root [0:RTW];
    logic [PW-1:0]  r_pay  [0:RTW];
    logic           r_v    [0:RTW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_rem[0]  <= RW'(i_rad);
        r_root[0] <= '0;
        r_pay[0]  <= i_pay;
    end

    for (genvar k = 0; k < RTW; k++) begin : g_bit
        localparam int B = RTW - 1 - k;
        logic [RW-1:0] n_trial;
        assign n_trial = (RW'(r_root[k]) << (B + 1)) + (RW'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_pay[k+1] <= r_pay[k];
            if (r_rem[k] >= n_trial) begin
                r_rem[k+1]  <= r_rem[k] - n_trial;
                r_root[k+1] <= r_root[k] | (RTW'(1) << B);
            end else begin
                r_rem[k+1]  <= r_rem[k];
                r_root[k+1] <= r_root[k];
            end
        end
    end

    assign o_valid = r_v[RTW];
    assign o_root  = r_root[RTW];
    assign o_pay   = r_pay[RTW];
endmodule

### sv/qte_cordic.sv
// Pipelined vectoring CORDIC atan2 with rounding to Q3.13 and saturation.
// Depends on qte_pkg.
module qte_cordic import qte_pkg::*; #(
    parameter int ITER  = 16,
    parameter int OW    = 16,
    parameter int LIMIT = 25736
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [XW-1:0] i_x,
    output logic                 o_valid,
    output logic signed [OW-1:0] o_angle
);
    localparam logic signed [ZW-1:0] RND = ZW'(65536);
    localparam logic signed [ZW-1:0] LIM = ZW'(LIMIT);

    logic signed [XW-1:0] r_x    [0:ITER];
    logic signed [XW-1:0] r_y    [0:ITER];
    logic signed [ZW-1:0] r_z    [0:ITER];
    logic                 r_zero [0:ITER];
    logic                 r_v    [0:ITER];
    logic signed [OW-1:0] r_ang;
    logic                 r_ov;

    // quadrant fold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_zero[0] <= (i_x == '0) && (i_y == '0);
        if (i_x < 0) begin
            r_x[0] <= -i_x;
            r_y[0] <= -i_y;
            r_z[0] <= (i_y >= 0) ? PI_Q30 : -PI_Q30;
        end else begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_z[0] <= '0;
        end
    end

    for (genvar k = 0; k < ITER; k++) begin : g_it
        localparam logic signed [ZW-1:0] ANG = ZW'(atan_q30(k));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_zero[k+1] <= r_zero[k];
            if (r_y[k] >= 0) begin
                r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] + ANG;
            end else begin
                r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] - ANG;
            end
        end
    end

    logic signed [ZW-1:0] n_sum;
    logic signed [ZW-1:0] n_sh;
    logic signed [ZW-1:0] n_sat;

    always_comb begin
        n_sum = r_z[ITER] + RND;
        n_sh  = n_sum >>> 17;
        if (r_zero[ITER]) begin
            n_sat = '0;
        end else if (n_sh > LIM) begin
            n_sat = LIM;
        end else if (n_sh < -LIM) begin
            n_sat = -LIM;
        end else begin
            n_sat = n_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[ITER];
        end
        r_ang <= n_sat[OW-1:0];
    end

    assign o_valid = r_ov;
    assign o_angle = r_ang;
endmodule

### sv/qte_checker.sv
// Port-level checker for quaternion_to_euler_angles, bound to the top level.
// Depends on quaternion_to_euler_angles_assert.svh.
`include "quaternion_to_euler_angles_assert.svh"

module qte_checker #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic signed [15:0] o_roll_angle,
    input logic signed [14:0] o_pitch_angle,
    input logic               o_pitch_clamped
);
    localparam int LAT = ANGLE_ITERATIONS + 36;

    `QTE_ASSERT_NEVER(a_never_busy, i_clk, i_rst_n, busy)
    `QTE_ASSERT_IMPL(a_valid_follows_start, i_clk, i_rst_n, o_valid, $past(start, LAT))
    `QTE_ASSERT_IMPL(a_clamp_pitch, i_clk, i_rst_n, o_valid && o_pitch_clamped, (o_pitch_angle == 15'sd12868) || (o_pitch_angle == -15'sd12868))
    `QTE_ASSERT_IMPL(a_roll_range, i_clk, i_rst_n, o_valid, (o_roll_angle <= 16'sd25736) && (o_roll_angle >= -16'sd25736))
endmodule

bind quaternion_to_euler_angles qte_checker #(
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
) u_qte_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_roll_angle    (o_roll_angle),
    .o_pitch_angle   (o_pitch_angle),
    .o_pitch_clamped (o_pitch_clamped)
);
